/* rtl/core/pcpc_pkg.sv */
// ----------------------------------------------------------------------------
// pcpc_pkg: shared definitions for the projective cubic point checker
// Register indexes, default field width and the stage control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package pcpc_pkg;

  // default width of field elements, coefficients and the modulus
  localparam int FIELD_BITS_DEF = 16;

  // width of the configuration register index
  localparam int CFG_IDX_W = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_C  = CFG_IDX_W'(3);

  // control shared by every pipeline stage
  typedef struct packed {
    logic adv;  // move all stages forward this cycle
  } stage_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/pcpc_red_cell.sv */
// ----------------------------------------------------------------------------
// pcpc_red_cell: one conditional-subtract cell of a modular reduction chain
// Subtracts p shifted left by K from every lane value that is not below it,
// and registers the lanes, the item's sideband and its valid bit.
// ----------------------------------------------------------------------------
`default_nettype none

module pcpc_red_cell import pcpc_pkg::*; #(
  parameter int W     = FIELD_BITS_DEF,
  parameter int VW    = 2 * FIELD_BITS_DEF,
  parameter int K     = 0,
  parameter int LANES = 1,
  parameter int SBW   = 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire stage_ctl_t            ctl,
  input  wire logic [W-1:0]          p,
  input  wire logic                  in_valid,
  input  wire logic [LANES*VW-1:0]   in_data,
  input  wire logic [SBW-1:0]        in_sb,
  output logic                       out_valid,
  output logic [LANES*VW-1:0]        out_data,
  output logic [SBW-1:0]             out_sb
);

  localparam int CW = VW + W;

  logic [CW-1:0]       pk;
  logic [LANES*VW-1:0] data_nxt;
  logic [LANES*VW-1:0] data_r;
  logic [SBW-1:0]      sb_r;
  logic                valid_r;

  // scaled modulus for this cell
  assign pk = CW'(p) << K;

  // subtract where the lane value is not below the scaled modulus
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [CW-1:0] ext;
    assign ext = CW'(in_data[l*VW +: VW]);
    assign data_nxt[l*VW +: VW] = (ext >= pk) ? VW'(ext - pk) : in_data[l*VW +: VW];
  end

  // hold the valid bit under stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.adv) begin
      valid_r <= in_valid;
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      data_r <= data_nxt;
      sb_r   <= in_sb;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
  assign out_sb    = sb_r;

endmodule

`default_nettype wire

/* rtl/core/pcpc_modchain.sv */
// ----------------------------------------------------------------------------
// pcpc_modchain: row of W reduction cells
// Reduces lane values below p * 2^W to the range [0, p), one quotient bit
// per cell from the top down, carrying a sideband alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module pcpc_modchain import pcpc_pkg::*; #(
  parameter int W     = FIELD_BITS_DEF,
  parameter int VW    = 2 * FIELD_BITS_DEF,
  parameter int LANES = 1,
  parameter int SBW   = 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire stage_ctl_t           ctl,
  input  wire logic [W-1:0]         p,
  input  wire logic                 in_valid,
  input  wire logic [LANES*VW-1:0]  in_data,
  input  wire logic [SBW-1:0]       in_sb,
  output logic                      out_valid,
  output logic [LANES*W-1:0]        out_data,
  output logic [SBW-1:0]            out_sb
);

  logic                valid_c [0:W];
  logic [LANES*VW-1:0] data_c  [0:W];
  logic [SBW-1:0]      sb_c    [0:W];

  assign valid_c[0] = in_valid;
  assign data_c[0]  = in_data;
  assign sb_c[0]    = in_sb;

  // one cell per quotient bit, highest first
  for (genvar i = 0; i < W; i++) begin : g_cell
    pcpc_red_cell #(
      .W(W), .VW(VW), .K(W - 1 - i), .LANES(LANES), .SBW(SBW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .p         (p),
      .in_valid  (valid_c[i]),
      .in_data   (data_c[i]),
      .in_sb     (sb_c[i]),
      .out_valid (valid_c[i+1]),
      .out_data  (data_c[i+1]),
      .out_sb    (sb_c[i+1])
    );
  end

  // drop the upper bits, which are zero after the last cell
  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign out_data[l*W +: W] = data_c[W][l*VW +: W];
  end

  assign out_valid = valid_c[W];
  assign out_sb    = sb_c[W];

endmodule

`default_nettype wire

/* rtl/core/pcpc_mulmod.sv */
// ----------------------------------------------------------------------------
// pcpc_mulmod: lane-parallel modular multiplier
// Registers the full products of each lane, then reduces them mod p in a
// chain of W cells. One item per cycle while ctl.adv is high.
// ----------------------------------------------------------------------------
`default_nettype none

module pcpc_mulmod import pcpc_pkg::*; #(
  parameter int W     = FIELD_BITS_DEF,
  parameter int LANES = 1,
  parameter int SBW   = 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire stage_ctl_t          ctl,
  input  wire logic [W-1:0]        p,
  input  wire logic                in_valid,
  input  wire logic [LANES*W-1:0]  in_a,
  input  wire logic [LANES*W-1:0]  in_b,
  input  wire logic [SBW-1:0]      in_sb,
  output logic                     out_valid,
  output logic [LANES*W-1:0]       out_data,
  output logic [SBW-1:0]           out_sb
);

  localparam int PW = 2 * W;

  logic [LANES*PW-1:0] prod_nxt;
  logic [LANES*PW-1:0] prod_r;
  logic [SBW-1:0]      sb_r;
  logic                valid_r;

  // one multiplier per lane
  for (genvar l = 0; l < LANES; l++) begin : g_mul
    assign prod_nxt[l*PW +: PW] = PW'(in_a[l*W +: W]) * PW'(in_b[l*W +: W]);
  end

  // hold the valid bit under stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.adv) begin
      valid_r <= in_valid;
    end
  end

  // register products
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      prod_r <= prod_nxt;
      sb_r   <= in_sb;
    end
  end

  pcpc_modchain #(.W(W), .VW(PW), .LANES(LANES), .SBW(SBW)) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .p         (p),
    .in_valid  (valid_r),
    .in_data   (prod_r),
    .in_sb     (sb_r),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_sb    (out_sb)
  );

endmodule

`default_nettype wire

/* rtl/core/projective_cubic_point_check.sv */
// ----------------------------------------------------------------------------
// projective_cubic_point_check: cubic membership test for projective points
// Checks y^2 z == x^3 + a x^2 z + b x z^2 + c z^3 mod p for each point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one point (x, y, z) per item.
//   Output channel out_valid/out_ready returns one item per point: the
//   on-curve flag and the coordinates reduced mod p.
//   Configuration channel cfg_valid/cfg_ready writes modulus (index 0),
//   coef_a, coef_b, coef_c (1..3); other indexes are ignored. A modulus
//   below two acts as two. Write only while no item is in flight.
// Throughput: one item per cycle while the output is not stalled, set by
//   the fully pipelined chains of reduction cells; every stage moves together.
// Pipeline: input reduction chain, three multiply-reduce rounds, each a
//   product register and a chain of FIELD_BITS reduction cells, one
//   modular add stage and the output register.
// Reset: the pipeline empties, modulus returns to two and the coefficients
//   to zero. A stall at the output freezes the whole pipeline and drops
//   in_ready until the waiting item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module projective_cubic_point_check import pcpc_pkg::*; #(
  parameter int FIELD_BITS = FIELD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [FIELD_BITS-1:0] in_coord_x,
  input  wire logic [FIELD_BITS-1:0] in_coord_y,
  input  wire logic [FIELD_BITS-1:0] in_coord_z,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_on_curve,
  output logic [FIELD_BITS-1:0]      out_x,
  output logic [FIELD_BITS-1:0]      out_y,
  output logic [FIELD_BITS-1:0]      out_z,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [FIELD_BITS-1:0] cfg_data
);

  localparam int W = FIELD_BITS;

  stage_ctl_t   ctl;
  logic [W-1:0] eff_p_r;
  logic [W-1:0] coef_a_r;
  logic [W-1:0] coef_b_r;
  logic [W-1:0] coef_c_r;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_p_r  <= W'(2);
      coef_a_r <= '0;
      coef_b_r <= '0;
      coef_c_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODULUS: eff_p_r  <= (cfg_data < W'(2)) ? W'(2) : cfg_data;
        REG_COEF_A:  coef_a_r <= cfg_data;
        REG_COEF_B:  coef_b_r <= cfg_data;
        REG_COEF_C:  coef_c_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // advance every stage unless the output item is held
  logic out_valid_r;
  assign ctl.adv  = !out_valid_r || out_ready;
  assign in_ready = ctl.adv;

  // reduce coordinates; coefficients ride along unreduced, the products
  // downstream stay below p * 2^W and reduce fully anyway
  logic         s0_valid;
  logic [3*W-1:0] s0_xyz;
  logic [3*W-1:0] s0_abc;

  pcpc_modchain #(.W(W), .VW(W), .LANES(3), .SBW(3*W)) u_in_red (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .p         (eff_p_r),
    .in_valid  (in_valid && ctl.adv),
    .in_data   ({in_coord_z, in_coord_y, in_coord_x}),
    .in_sb     ({coef_c_r, coef_b_r, coef_a_r}),
    .out_valid (s0_valid),
    .out_data  (s0_xyz),
    .out_sb    (s0_abc)
  );

  logic [W-1:0] x0, y0, z0;
  assign x0 = s0_xyz[0 +: W];
  assign y0 = s0_xyz[W +: W];
  assign z0 = s0_xyz[2*W +: W];

  // round 1: xx, zz, yy
  logic           s1_valid;
  logic [3*W-1:0] s1_d;
  logic [6*W-1:0] s1_sb;

  pcpc_mulmod #(.W(W), .LANES(3), .SBW(6*W)) u_mm1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .p         (eff_p_r),
    .in_valid  (s0_valid),
    .in_a      ({y0, z0, x0}),
    .in_b      ({y0, z0, x0}),
    .in_sb     ({s0_abc, s0_xyz}),
    .out_valid (s1_valid),
    .out_data  (s1_d),
    .out_sb    (s1_sb)
  );

  logic [W-1:0] xx1, zz1, yy1, x1, y1, z1, a1, b1, c1;
  assign xx1 = s1_d[0 +: W];
  assign zz1 = s1_d[W +: W];
  assign yy1 = s1_d[2*W +: W];
  assign x1  = s1_sb[0 +: W];
  assign y1  = s1_sb[W +: W];
  assign z1  = s1_sb[2*W +: W];
  assign a1  = s1_sb[3*W +: W];
  assign b1  = s1_sb[4*W +: W];
  assign c1  = s1_sb[5*W +: W];

  // round 2: lhs = yy z, u = b zz, v = a xx, w = c zz
  logic           s2_valid;
  logic [4*W-1:0] s2_d;
  logic [4*W-1:0] s2_sb;

  pcpc_mulmod #(.W(W), .LANES(4), .SBW(4*W)) u_mm2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .p         (eff_p_r),
    .in_valid  (s1_valid),
    .in_a      ({c1, a1, b1, yy1}),
    .in_b      ({zz1, xx1, zz1, z1}),
    .in_sb     ({xx1, z1, y1, x1}),
    .out_valid (s2_valid),
    .out_data  (s2_d),
    .out_sb    (s2_sb)
  );

  logic [W:0] sum1, sum2;
  assign sum1 = (W+1)'(s2_sb[3*W +: W]) + (W+1)'(s2_d[W +: W]);
  assign sum2 = (W+1)'(s2_d[2*W +: W]) + (W+1)'(s2_d[3*W +: W]);

  // add stage: s1 = xx + b zz, s2 = a xx + c zz, both mod p
  logic         add_valid_r;
  logic [W-1:0] add_s1_r, add_s2_r, add_lhs_r, add_x_r, add_y_r, add_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      add_valid_r <= 1'b0;
    end else if (ctl.adv) begin
      add_valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      add_s1_r  <= (sum1 >= (W+1)'(eff_p_r)) ? W'(sum1 - (W+1)'(eff_p_r)) : W'(sum1);
      add_s2_r  <= (sum2 >= (W+1)'(eff_p_r)) ? W'(sum2 - (W+1)'(eff_p_r)) : W'(sum2);
      add_lhs_r <= s2_d[0 +: W];
      add_x_r   <= s2_sb[0 +: W];
      add_y_r   <= s2_sb[W +: W];
      add_z_r   <= s2_sb[2*W +: W];
    end
  end

  // round 3: r1 = x s1, r2 = z s2
  logic           s3_valid;
  logic [2*W-1:0] s3_d;
  logic [4*W-1:0] s3_sb;

  pcpc_mulmod #(.W(W), .LANES(2), .SBW(4*W)) u_mm3 (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .p         (eff_p_r),
    .in_valid  (add_valid_r),
    .in_a      ({add_z_r, add_x_r}),
    .in_b      ({add_s2_r, add_s1_r}),
    .in_sb     ({add_lhs_r, add_z_r, add_y_r, add_x_r}),
    .out_valid (s3_valid),
    .out_data  (s3_d),
    .out_sb    (s3_sb)
  );

  logic [W:0]   rsum;
  logic [W-1:0] rhs;
  assign rsum = (W+1)'(s3_d[0 +: W]) + (W+1)'(s3_d[W +: W]);
  assign rhs  = (rsum >= (W+1)'(eff_p_r)) ? W'(rsum - (W+1)'(eff_p_r)) : W'(rsum);

  // output register: compare both sides
  logic         on_curve_r;
  logic [W-1:0] x_r, y_r, z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.adv) begin
      out_valid_r <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      on_curve_r <= (rhs == s3_sb[3*W +: W]);
      x_r        <= s3_sb[0 +: W];
      y_r        <= s3_sb[W +: W];
      z_r        <= s3_sb[2*W +: W];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_on_curve = on_curve_r;
  assign out_x        = x_r;
  assign out_y        = y_r;
  assign out_z        = z_r;

  // the all-zero point always satisfies the cubic
  a_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_x == '0 && out_y == '0 && out_z == '0) |-> out_on_curve)
    else $error("zero point reported off curve");

  // echoed coordinates are fully reduced
  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_x < eff_p_r && out_y < eff_p_r && out_z < eff_p_r))
    else $error("coordinate not reduced mod p");

  // effective modulus never drops below two
  a_mod_min: assert property (@(posedge clk) disable iff (!rst_n)
    eff_p_r >= W'(2))
    else $error("effective modulus below two");

  // a held output item freezes the intake
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while output stalled");

endmodule

`default_nettype wire

/* bench/projective_cubic_point_check_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// projective_cubic_point_check_test: bench for the projective cubic checker
// Drives projective points through the valid/ready input channel under
// several modulus and coefficient settings, predicts the on-curve flag and
// the reduced coordinates for each item and compares every returned item.
// ----------------------------------------------------------------------------
`default_nettype none

module projective_cubic_point_check_test;
  import pcpc_pkg::*;

  localparam int FB = FIELD_BITS_DEF;
  localparam int PIPE_LAT = 4 * FB + 5;
  localparam int STALL_LIMIT = 20000;
  localparam int RAND_ITEMS = 930;

  typedef logic [FB-1:0] fe_t;

  typedef struct packed {
    logic on;
    fe_t  x;
    fe_t  y;
    fe_t  z;
  } point_res_t;

  // directed row: point, expected flag when given
  typedef struct {
    fe_t  x;
    fe_t  y;
    fe_t  z;
    logic has_exp;
    logic exp_on;
  } point_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  fe_t  in_coord_x;
  fe_t  in_coord_y;
  fe_t  in_coord_z;
  logic out_valid;
  logic out_ready;
  logic out_on_curve;
  fe_t  out_x;
  fe_t  out_y;
  fe_t  out_z;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  fe_t  cfg_data;

  // predictor copy of the register file
  fe_t reg_mod;
  fe_t reg_a;
  fe_t reg_b;
  fe_t reg_c;

  point_res_t pending_q[$];
  int  mismatch_cnt;
  int  idle_cycles;
  bit  no_idle;

  projective_cubic_point_check u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_coord_x   (in_coord_x),
    .in_coord_y   (in_coord_y),
    .in_coord_z   (in_coord_z),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_on_curve (out_on_curve),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // compute flag and reduced coordinates for one point
  function automatic point_res_t cubic_check(fe_t px, fe_t py, fe_t pz);
    longint unsigned m, x, y, z, a, b, c, lhs, rhs;
    point_res_t r;
    m = (reg_mod < 2) ? 2 : reg_mod;
    x = px % m;
    y = py % m;
    z = pz % m;
    a = reg_a % m;
    b = reg_b % m;
    c = reg_c % m;
    lhs = (((y * y) % m) * z) % m;
    rhs = (((x * x) % m) * x) % m;
    rhs = (rhs + (((a * ((x * x) % m)) % m) * z) % m) % m;
    rhs = (rhs + (((b * x) % m) * ((z * z) % m)) % m) % m;
    rhs = (rhs + (((c * ((z * z) % m)) % m) * z) % m) % m;
    r.on = (lhs == rhs);
    r.x = fe_t'(x);
    r.y = fe_t'(y);
    r.z = fe_t'(z);
    return r;
  endfunction

  // write one register and mirror it in the predictor
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, fe_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MODULUS: reg_mod = val;
      REG_COEF_A:  reg_a = val;
      REG_COEF_B:  reg_b = val;
      REG_COEF_C:  reg_c = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // offer one point; optionally pin the expected flag
  task automatic send_point(fe_t x, fe_t y, fe_t z, logic has_exp, logic exp_on);
    point_res_t r;
    int gap;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_coord_x <= x;
    in_coord_y <= y;
    in_coord_z <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = cubic_check(x, y, z);
    if (has_exp) r.on = exp_on;
    pending_q.push_back(r);
  endtask

  // wait for every expected item, then let the pipe drain
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 5) @(posedge clk);
  endtask

  // random receiver stalls in bursts
  initial begin
    int burst;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!no_idle && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 12);
        out_ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // compare each returned item with the oldest expectation
  always @(posedge clk) begin
    point_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected item x=%0d y=%0d z=%0d", out_x, out_y, out_z);
      end else begin
        e = pending_q.pop_front();
        if (e.on !== out_on_curve || e.x !== out_x || e.y !== out_y || e.z !== out_z) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch exp on=%0d x=%0d y=%0d z=%0d got on=%0d x=%0d y=%0d z=%0d",
                     e.on, e.x, e.y, e.z, out_on_curve, out_x, out_y, out_z);
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // random setting; small moduli make on-curve hits common
  task automatic rand_config(bit wide);
    write_reg(REG_MODULUS, wide ? fe_t'($urandom) : fe_t'($urandom_range(0, 40)));
    write_reg(REG_COEF_A, fe_t'($urandom));
    write_reg(REG_COEF_B, fe_t'($urandom));
    write_reg(REG_COEF_C, fe_t'($urandom));
  endtask

  initial begin
    point_row_t rows[$];
    fe_t x, y, z;
    int n;
    mismatch_cnt = 0;
    idle_cycles  = 0;
    no_idle      = 1'b0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_coord_x <= '0;
    in_coord_y <= '0;
    in_coord_z <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    reg_mod = 2;
    reg_a = 0;
    reg_b = 0;
    reg_c = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // after reset: mod 2, zero coefficients, curve y^2 z = x^3
    rows.push_back('{16'd0, 16'd0, 16'd0, 1'b1, 1'b1});
    rows.push_back('{16'd1, 16'd1, 16'd1, 1'b1, 1'b1});
    rows.push_back('{16'd1, 16'd0, 16'd1, 1'b1, 1'b0});
    rows.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1});
    rows.push_back('{16'hFFFE, 16'h0001, 16'hFFFF, 1'b1, 1'b0});
    foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].z, rows[i].has_exp, rows[i].exp_on);
    drain();

    // modulus 7, curve y^2 z = x^3 + x z^2 + 3 z^3; out-of-range coefficients
    write_reg(REG_MODULUS, 16'd7);
    write_reg(REG_COEF_A, 16'd7);
    write_reg(REG_COEF_B, 16'd8);
    write_reg(REG_COEF_C, 16'd3);
    write_reg(CFG_IDX_W'(9), 16'd5);
    rows.delete();
    rows.push_back('{16'd0, 16'd1, 16'd0, 1'b1, 1'b1});
    rows.push_back('{16'd0, 16'd0, 16'd0, 1'b1, 1'b1});
    rows.push_back('{16'd4, 16'd1, 16'd1, 1'b0, 1'b0});
    rows.push_back('{16'd11, 16'd8, 16'd8, 1'b0, 1'b0});
    rows.push_back('{16'hFFFF, 16'h0000, 16'hFFFF, 1'b0, 1'b0});
    rows.push_back('{16'h0000, 16'hFFFF, 16'h0001, 1'b0, 1'b0});
    foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].z, rows[i].has_exp, rows[i].exp_on);
    drain();

    // modulus below two acts as two; then largest modulus, composite, extremes
    write_reg(REG_MODULUS, 16'd0);
    send_point(16'd3, 16'd5, 16'd1, 1'b1, 1'b1);
    drain();
    write_reg(REG_MODULUS, 16'd1);
    send_point(16'd2, 16'd1, 16'd1, 1'b1, 1'b1);
    drain();
    write_reg(REG_MODULUS, 16'hFFFF);
    write_reg(REG_COEF_A, 16'hFFFF);
    write_reg(REG_COEF_B, 16'hFFFE);
    write_reg(REG_COEF_C, 16'h0000);
    send_point(16'hFFFE, 16'hFFFE, 16'hFFFE, 1'b0, 1'b0);
    send_point(16'hFFFF, 16'h1234, 16'hFFFF, 1'b0, 1'b0);
    send_point(16'd0, 16'd0, 16'hFFFE, 1'b0, 1'b0);
    drain();
    write_reg(REG_MODULUS, 16'd15);
    send_point(16'd3, 16'd0, 16'd1, 1'b0, 1'b0);
    send_point(16'd20, 16'd30, 16'd40, 1'b0, 1'b0);
    drain();

    // random phases, each under a fresh setting
    n = 0;
    while (n < RAND_ITEMS) begin
      rand_config($urandom_range(0, 3) == 0);
      if (n > RAND_ITEMS - 120) no_idle = 1'b1;
      repeat (60) begin
        if ((reg_mod > 64) || $urandom_range(0, 3) == 0) begin
          x = fe_t'($urandom);
          y = fe_t'($urandom);
          z = fe_t'($urandom);
        end else begin
          x = fe_t'($urandom_range(0, 63));
          y = fe_t'($urandom_range(0, 63));
          z = fe_t'($urandom_range(0, 63));
        end
        send_point(x, y, z, 1'b0, 1'b0);
        n++;
      end
      drain();
    end

    if (mismatch_cnt == 0 && pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
rtl/core/pcpc_pkg.sv
rtl/core/pcpc_red_cell.sv
rtl/core/pcpc_modchain.sv
rtl/core/pcpc_mulmod.sv
rtl/core/projective_cubic_point_check.sv
bench/projective_cubic_point_check_test.sv
